/* rtl/core/bitplane_framebuffer_scanout_core_defines.svh */
// assertion macros used by the scanout core controller
`ifndef BITPLANE_FRAMEBUFFER_SCANOUT_CORE_DEFINES_SVH
`define BITPLANE_FRAMEBUFFER_SCANOUT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BFSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define BFSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bfsc_pkg.sv */
// shared types and constants of the bitplane scanout core
package bfsc_pkg;

    // color channels
    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // horizontal bit offset and rgb565 bit per channel
    localparam int unsigned CH_SHIFT     [NUM_CH] = '{8, 6, 4};
    localparam int unsigned CH_COLOR_BIT [NUM_CH] = '{11, 5, 0};

    // field widths
    localparam int OP_W    = 3;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int COLOR_W = 16;
    localparam int BI_W    = 7;
    localparam int LINE_W  = 10;
    localparam int ROW_W   = 15;
    localparam int BYTE_W  = 8;

    // input tdata layout
    localparam int X_LSB       = 0;
    localparam int Y_LSB       = X_LSB + X_W;
    localparam int COLOR_LSB   = Y_LSB + Y_W;
    localparam int BI_LSB      = COLOR_LSB + COLOR_W;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    // config port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [LINE_W-1:0] VSYNC_START_RST = 10'd490;
    localparam logic [LINE_W-1:0] VSYNC_END_RST   = 10'd492;
    localparam logic [LINE_W-1:0] TOTAL_LINES_RST = 10'd525;

    typedef enum logic [OP_W-1:0] {
        OP_SET_PIXEL = 3'd0,
        OP_FILL      = 3'd1,
        OP_FLIP      = 3'd2,
        OP_FETCH     = 3'd3,
        OP_END_LINE  = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [LINE_W-1:0] vsync_start;
        logic [LINE_W-1:0] vsync_end;
        logic [LINE_W-1:0] total_lines;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic sweep_clear;
        logic sweep_run;
        logic pix_prep;
        logic pix_read;
        logic pix_write;
        logic fetch_read;
        logic eol;
        logic flip;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        opcode_t opcode;
        logic    pix_ok;
        logic    sweep_last;
    } sts_t;

endpackage

/* rtl/core/bitplane_framebuffer_scanout_core.sv */
// top level of the double-buffered bitplane framebuffer with scanout
// Double-buffered 1 bit per channel rgb framebuffer with line-doubled scanout. Each item
// (opcode in s_tuser) draws, fills, flips, fetches one byte of the latched scan row, or
// ends a line; every item gives exactly one result on the m side, carrying the fetched
// bytes and the vertical timing after that item. Items are handled one at a time by a
// controller stepping a datapath around six single-port-write plane memories (one per
// channel and buffer, LINE_BYTES*VISIBLE_LINES/2 bytes each, registered read). Flip, end
// of line, fetch (one memory read) and unused opcodes pass through an execute state; set
// pixel adds a read and a write state for its read-modify-write, skipped when the pixel
// lies outside the visible area; fill walks every byte of the drawing planes one address
// per cycle. A result that waits for m_tready holds the next item in its last cycle.
// After reset a clearing pass over every address zeroes all planes, during which s_tready
// stays low; the apb registers can be written at any time the block is idle.
module bitplane_framebuffer_scanout_core #(
    parameter int LINE_BYTES     = 100,
    parameter int VISIBLE_LINES  = 480,
    parameter int VISIBLE_BYTES  = 80,
    parameter int VISIBLE_WIDTH  = 640,
    parameter int VISIBLE_HEIGHT = 240
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_x[9:0], pixel_y[18:10], color[34:19], byte_index[41:35], zero[47:42]
    input  logic [bfsc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode[2:0]
    input  logic [bfsc_pkg::OP_W-1:0]           s_tuser,
    // result item stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // red_byte[7:0], green_byte[15:8], blue_byte[23:16], vsync_active[24],
    // current_line[34:25], in_vblank[35], zero[39:36]
    output logic [bfsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bfsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bfsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    bfsc_pkg::cfg_t cfg;
    bfsc_pkg::cmd_t cmd;
    bfsc_pkg::sts_t sts;

    // timing registers
    bfsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencing
    bfsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // planes and timing datapath
    bfsc_datapath #(
        .LINE_BYTES     (LINE_BYTES),
        .VISIBLE_LINES  (VISIBLE_LINES),
        .VISIBLE_BYTES  (VISIBLE_BYTES),
        .VISIBLE_WIDTH  (VISIBLE_WIDTH),
        .VISIBLE_HEIGHT (VISIBLE_HEIGHT)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

/* rtl/core/bfsc_ram.sv */
// generic single-write, single-read ram with registered read data
module bfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/bfsc_cfg.sv */
// apb register block for the vertical timing settings
module bfsc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bfsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bfsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output bfsc_pkg::cfg_t                      cfg
);

    localparam logic [1:0] REG_VSYNC_START = 2'd0;
    localparam logic [1:0] REG_VSYNC_END   = 2'd1;
    localparam logic [1:0] REG_TOTAL_LINES = 2'd2;

    logic [1:0]                        reg_idx;
    logic                              wr_en;
    logic [bfsc_pkg::LINE_W-1:0]       wr_val;
    logic [bfsc_pkg::LINE_W-1:0]       vsync_start_reg;
    logic [bfsc_pkg::LINE_W-1:0]       vsync_end_reg;
    logic [bfsc_pkg::LINE_W-1:0]       total_lines_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign wr_val  = pwdata[bfsc_pkg::LINE_W-1:0];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsync_start_reg <= bfsc_pkg::VSYNC_START_RST;
            vsync_end_reg   <= bfsc_pkg::VSYNC_END_RST;
            total_lines_reg <= bfsc_pkg::TOTAL_LINES_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_VSYNC_START: vsync_start_reg <= wr_val;
                REG_VSYNC_END:   vsync_end_reg   <= wr_val;
                REG_TOTAL_LINES: total_lines_reg <= wr_val;
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_VSYNC_START: prdata = bfsc_pkg::APB_DATA_W'(vsync_start_reg);
            REG_VSYNC_END:   prdata = bfsc_pkg::APB_DATA_W'(vsync_end_reg);
            REG_TOTAL_LINES: prdata = bfsc_pkg::APB_DATA_W'(total_lines_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.vsync_start = vsync_start_reg;
    assign cfg.vsync_end   = vsync_end_reg;
    assign cfg.total_lines = total_lines_reg;

endmodule

/* rtl/core/bfsc_ctrl.sv */
// controller state machine: sequences clear, pixel, fill, flip, fetch and line items
`include "bitplane_framebuffer_scanout_core_defines.svh"

module bfsc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output bfsc_pkg::cmd_t  cmd,
    input  bfsc_pkg::sts_t  sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_clear = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.load_item = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (sts.opcode)
                    bfsc_pkg::OP_SET_PIXEL:
                    begin
                        if (sts.pix_ok)
                        begin
                            cmd.pix_prep = 1'b1;
                            state_next   = ST_PIX_RD;
                        end
                    end
                    bfsc_pkg::OP_FILL:     state_next     = ST_FILL;
                    bfsc_pkg::OP_FLIP:     cmd.flip       = 1'b1;
                    bfsc_pkg::OP_FETCH:    cmd.fetch_read = 1'b1;
                    bfsc_pkg::OP_END_LINE: cmd.eol        = 1'b1;
                    default:               ;
                endcase
            end
            ST_PIX_RD:
            begin
                cmd.pix_read = 1'b1;
                state_next   = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.pix_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_FILL:
            begin
                cmd.sweep_run = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & ~m_tready);

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // checks
    `BFSC_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, (!out_valid_reg || m_tready),
        "result loaded over one still waiting")
    `BFSC_ASSERT_NEXT(a_accept_goes_exec, (s_tvalid && s_tready), (state_reg == ST_EXEC),
        "accepted item not executed next cycle")
    `BFSC_ASSERT_NEXT(a_clear_runs_to_end, (state_reg == ST_CLEAR && !sts.sweep_last),
        (state_reg == ST_CLEAR), "clearing pass left before last entry")

endmodule

/* rtl/core/bfsc_datapath.sv */
// datapath: plane memories, scan timing registers, address math and result register
module bfsc_datapath #(
    parameter int LINE_BYTES     = 100,
    parameter int VISIBLE_LINES  = 480,
    parameter int VISIBLE_BYTES  = 80,
    parameter int VISIBLE_WIDTH  = 640,
    parameter int VISIBLE_HEIGHT = 240
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bfsc_pkg::cmd_t                       cmd,
    output bfsc_pkg::sts_t                       sts,
    input  bfsc_pkg::cfg_t                       cfg,
    input  logic [bfsc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [bfsc_pkg::OP_W-1:0]            s_tuser,
    output logic [bfsc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int PLANE_BYTES = LINE_BYTES * (VISIBLE_LINES / 2);
    localparam int AW          = $clog2(PLANE_BYTES);
    localparam int CW          = $clog2(LINE_BYTES);
    localparam int FA_W        = 17;
    localparam int NCH         = bfsc_pkg::NUM_CH;
    localparam int BW          = bfsc_pkg::BYTE_W;

    // item registers
    bfsc_pkg::opcode_t                 op_reg;
    logic [bfsc_pkg::X_W-1:0]          x_reg;
    logic [bfsc_pkg::Y_W-1:0]          y_reg;
    logic [bfsc_pkg::COLOR_W-1:0]      color_reg;
    logic [bfsc_pkg::BI_W-1:0]         bi_reg;

    // scan state
    logic                              shown_reg;
    logic [bfsc_pkg::LINE_W-1:0]       line_reg;
    logic [bfsc_pkg::LINE_W-1:0]       line_next;
    logic [bfsc_pkg::ROW_W-1:0]        row_off_reg;
    logic [bfsc_pkg::ROW_W-1:0]        row_off_next;
    logic [bfsc_pkg::ROW_W-1:0]        send_row_reg;
    logic [bfsc_pkg::ROW_W-1:0]        send_row_next;
    logic                              blank_reg;
    logic                              blank_next;
    logic                              vsync_reg;
    logic                              vsync_next;
    logic [bfsc_pkg::ROW_W-1:0]        row_base;
    logic [bfsc_pkg::LINE_W-1:0]       line_inc;

    // pixel address stage
    logic [FA_W-1:0]                   pix_row;
    logic [10:0]                       pix_pos  [NCH];
    logic [FA_W-1:0]                   pix_full [NCH];
    logic [NCH-1:0]                    ch_on;
    logic [AW-1:0]                     pix_addr_reg [NCH];
    logic [BW-1:0]                     pix_mask_reg [NCH];
    logic [NCH-1:0]                    pix_in_reg;
    logic [BW-1:0]                     pix_new [NCH];

    // sweep counters for fill and clear
    logic [AW-1:0]                     sweep_addr_reg;
    logic [CW-1:0]                     col_reg;
    logic                              row_nz_reg;
    logic                              sweep_step;
    logic                              sweep_last;
    logic                              fill_hit;

    // fetch
    logic [FA_W-1:0]                   fetch_full;
    logic                              fetch_ok;
    logic                              fetch_ok_reg;

    // memories
    logic                              ram_we    [NCH][2];
    logic [AW-1:0]                     ram_waddr [NCH];
    logic [BW-1:0]                     ram_wdata [NCH];
    logic [AW-1:0]                     ram_raddr [NCH];
    logic                              ram_re;
    logic [BW-1:0]                     ram_rdata [NCH][2];
    logic [BW-1:0]                     shown_rd  [NCH];
    logic [BW-1:0]                     draw_rd   [NCH];

    // result register
    logic [BW-1:0]                     out_byte_reg [NCH];
    logic                              out_vsync_reg;
    logic [bfsc_pkg::LINE_W-1:0]       out_line_reg;
    logic                              out_vblank_reg;

    // capture item fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= bfsc_pkg::opcode_t'(s_tuser);
            x_reg     <= s_tdata[bfsc_pkg::X_LSB +: bfsc_pkg::X_W];
            y_reg     <= s_tdata[bfsc_pkg::Y_LSB +: bfsc_pkg::Y_W];
            color_reg <= s_tdata[bfsc_pkg::COLOR_LSB +: bfsc_pkg::COLOR_W];
            bi_reg    <= s_tdata[bfsc_pkg::BI_LSB +: bfsc_pkg::BI_W];
        end
    end

    // end of line timing
    always_comb
    begin
        row_base      = (line_reg == '0) ? '0 : row_off_reg;
        line_inc      = line_reg + 10'd1;
        row_off_next  = line_reg[0] ? (row_base + bfsc_pkg::ROW_W'(LINE_BYTES)) : row_base;
        blank_next    = !(line_reg < bfsc_pkg::LINE_W'(VISIBLE_LINES));
        send_row_next = blank_next ? send_row_reg : row_base;
        vsync_next    = vsync_reg;
        line_next     = line_inc;
        if (line_inc == cfg.vsync_start)
        begin
            vsync_next = 1'b1;
        end
        else if (line_inc == cfg.vsync_end)
        begin
            vsync_next = 1'b0;
        end
        else if (line_inc == cfg.total_lines)
        begin
            line_next = '0;
        end
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg    <= 1'b0;
            line_reg     <= '0;
            row_off_reg  <= '0;
            send_row_reg <= '0;
            blank_reg    <= 1'b1;
            vsync_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.flip)
            begin
                shown_reg <= ~shown_reg;
            end
            if (cmd.eol)
            begin
                line_reg     <= line_next;
                row_off_reg  <= row_off_next;
                send_row_reg <= send_row_next;
                blank_reg    <= blank_next;
                vsync_reg    <= vsync_next;
            end
        end
    end

    // pixel byte address, bit mask and plane bound per channel
    always_comb
    begin
        pix_row = FA_W'(y_reg) * FA_W'(LINE_BYTES);
        for (int c = 0; c < NCH; c++)
        begin
            pix_pos[c]  = 11'(x_reg) + 11'(bfsc_pkg::CH_SHIFT[c]);
            pix_full[c] = pix_row + FA_W'(pix_pos[c][10:3]);
            ch_on[c]    = color_reg[bfsc_pkg::CH_COLOR_BIT[c]];
        end
    end

    assign sts.pix_ok = (x_reg < bfsc_pkg::X_W'(VISIBLE_WIDTH))
                      && (10'(y_reg) < 10'(VISIBLE_HEIGHT));

    always_ff @(posedge clk)
    begin
        if (cmd.pix_prep)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                pix_addr_reg[c] <= pix_full[c][AW-1:0];
                pix_mask_reg[c] <= 8'h80 >> pix_pos[c][2:0];
                pix_in_reg[c]   <= pix_full[c] < FA_W'(PLANE_BYTES);
            end
        end
    end

    // sweep over one plane, tracking column for the fill window
    assign sweep_step = cmd.sweep_clear | cmd.sweep_run;
    assign sweep_last = (sweep_addr_reg == AW'(PLANE_BYTES - 1));
    assign fill_hit   = ((col_reg != '0) && (8'(col_reg) <= 8'(VISIBLE_BYTES)))
                      || ((col_reg == '0) && row_nz_reg && (VISIBLE_BYTES >= LINE_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
            col_reg        <= '0;
            row_nz_reg     <= 1'b0;
        end
        else if (sweep_step)
        begin
            if (sweep_last)
            begin
                sweep_addr_reg <= '0;
                col_reg        <= '0;
                row_nz_reg     <= 1'b0;
            end
            else
            begin
                sweep_addr_reg <= sweep_addr_reg + AW'(1);
                if (col_reg == CW'(LINE_BYTES - 1))
                begin
                    col_reg    <= '0;
                    row_nz_reg <= 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    assign sts.sweep_last = sweep_last;
    assign sts.opcode     = op_reg;

    // fetch address and bounds
    assign fetch_full = FA_W'(send_row_reg) + FA_W'(bi_reg);
    assign fetch_ok   = !blank_reg && (8'(bi_reg) < 8'(LINE_BYTES))
                      && (fetch_full < FA_W'(PLANE_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_ok_reg <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            fetch_ok_reg <= 1'b0;
        end
        else if (cmd.fetch_read)
        begin
            fetch_ok_reg <= fetch_ok;
        end
    end

    // memory port steering
    assign ram_re = cmd.fetch_read | cmd.pix_read;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            shown_rd[c] = shown_reg ? ram_rdata[c][1] : ram_rdata[c][0];
            draw_rd[c]  = shown_reg ? ram_rdata[c][0] : ram_rdata[c][1];
            pix_new[c]  = ch_on[c] ? (draw_rd[c] | pix_mask_reg[c])
                                   : (draw_rd[c] & ~pix_mask_reg[c]);
            ram_raddr[c] = cmd.fetch_read ? fetch_full[AW-1:0] : pix_addr_reg[c];
            ram_waddr[c] = sweep_step ? sweep_addr_reg : pix_addr_reg[c];
            if (cmd.sweep_clear)
            begin
                ram_wdata[c] = '0;
            end
            else if (cmd.sweep_run)
            begin
                ram_wdata[c] = ch_on[c] ? 8'hFF : 8'h00;
            end
            else
            begin
                ram_wdata[c] = pix_new[c];
            end
            for (int b = 0; b < 2; b++)
            begin
                ram_we[c][b] = cmd.sweep_clear
                    || ((b[0] != shown_reg)
                        && ((cmd.sweep_run && (!ch_on[c] || fill_hit))
                            || (cmd.pix_write && pix_in_reg[c])));
            end
        end
    end

    for (genvar c = 0; c < NCH; c++)
    begin : g_ch
        for (genvar b = 0; b < 2; b++)
        begin : g_buf
            bfsc_ram #(
                .WIDTH (BW),
                .DEPTH (PLANE_BYTES)
            ) u_ram (
                .clk   (clk),
                .we    (ram_we[c][b]),
                .waddr (ram_waddr[c]),
                .wdata (ram_wdata[c]),
                .re    (ram_re),
                .raddr (ram_raddr[c]),
                .rdata (ram_rdata[c][b])
            );
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                out_byte_reg[c] <= fetch_ok_reg ? shown_rd[c] : '0;
            end
            out_vsync_reg  <= vsync_reg;
            out_line_reg   <= line_reg;
            out_vblank_reg <= !(line_reg < bfsc_pkg::LINE_W'(VISIBLE_LINES));
        end
    end

    assign m_tdata = {4'b0, out_vblank_reg, out_line_reg, out_vsync_reg,
                      out_byte_reg[bfsc_pkg::CH_BLUE], out_byte_reg[bfsc_pkg::CH_GREEN],
                      out_byte_reg[bfsc_pkg::CH_RED]};

endmodule

/* verif/tb_bitplane_framebuffer_scanout_core.sv */
`timescale 1ns / 1ps
// self-checking testbench for the bitplane framebuffer scanout core
module tb_bitplane_framebuffer_scanout_core;
    import bfsc_pkg::*;

    localparam int LINE_BYTES     = 100;
    localparam int VISIBLE_LINES  = 480;
    localparam int VISIBLE_BYTES  = 80;
    localparam int VISIBLE_WIDTH  = 640;
    localparam int VISIBLE_HEIGHT = 240;
    localparam int PLANE_BYTES    = LINE_BYTES * (VISIBLE_LINES / 2);

    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_PRINTED = 100;

    // register indexes of the timing registers
    localparam int REG_VSYNC_START = 0;
    localparam int REG_VSYNC_END   = 1;
    localparam int REG_TOTAL_LINES = 2;

    // opcodes that the block leaves without effect
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              vsync;
        logic [LINE_W-1:0] line;
        logic              vblank;
    } scan_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    bitplane_framebuffer_scanout_core #(
        .LINE_BYTES     (LINE_BYTES),
        .VISIBLE_LINES  (VISIBLE_LINES),
        .VISIBLE_BYTES  (VISIBLE_BYTES),
        .VISIBLE_WIDTH  (VISIBLE_WIDTH),
        .VISIBLE_HEIGHT (VISIBLE_HEIGHT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow framebuffer and scan timing state
    bit [BYTE_W-1:0] plane_mem [NUM_CH][2][PLANE_BYTES];
    bit              shown_buf  = 1'b0;
    bit [LINE_W-1:0] line_cnt   = '0;
    bit [ROW_W-1:0]  row_ofs    = '0;
    bit [ROW_W-1:0]  send_row   = '0;
    bit              send_blank = 1'b1;
    bit              vsync_lvl  = 1'b0;
    bit [LINE_W-1:0] cfg_vsync_start = VSYNC_START_RST;
    bit [LINE_W-1:0] cfg_vsync_end   = VSYNC_END_RST;
    bit [LINE_W-1:0] cfg_total_lines = TOTAL_LINES_RST;

    scan_result_t pending_scan_results [$];

    int mismatches  = 0;
    int cycle_count = 0;
    bit idle_on     = 1'b1;
    int hold_req    = 0;
    int fills_left  = 3;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                     cycle_count, what, want, got);
    endtask

    // expected result of one item, advancing the shadow state
    function automatic scan_result_t predict_scan_result(logic [OP_W-1:0] op,
                                                         logic [X_W-1:0] x,
                                                         logic [Y_W-1:0] y,
                                                         logic [COLOR_W-1:0] color,
                                                         logic [BI_W-1:0] bi);
        scan_result_t res;
        int unsigned  draw;
        int unsigned  pos;
        int unsigned  addr;
        res  = '0;
        draw = shown_buf ? 0 : 1;
        case (op)
            OP_SET_PIXEL:
            begin
                if (x < VISIBLE_WIDTH && y < VISIBLE_HEIGHT)
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        pos  = x + CH_SHIFT[ch];
                        addr = y * LINE_BYTES + (pos >> 3);
                        if (addr < PLANE_BYTES)
                        begin
                            if (color[CH_COLOR_BIT[ch]])
                                plane_mem[ch][draw][addr] |= 8'h80 >> (pos & 7);
                            else
                                plane_mem[ch][draw][addr] &= ~(8'h80 >> (pos & 7));
                        end
                    end
                end
            end
            OP_FILL:
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    if (color[CH_COLOR_BIT[ch]])
                    begin
                        // visible bytes of every row go to all ones
                        for (int r = 0; r < VISIBLE_LINES / 2; r++)
                            for (int k = 1; k <= VISIBLE_BYTES; k++)
                                if (r * LINE_BYTES + k < PLANE_BYTES)
                                    plane_mem[ch][draw][r * LINE_BYTES + k] = 8'hff;
                    end
                    else
                    begin
                        for (int a = 0; a < PLANE_BYTES; a++)
                            plane_mem[ch][draw][a] = '0;
                    end
                end
            end
            OP_FLIP:
                shown_buf = ~shown_buf;
            OP_FETCH:
            begin
                if (!send_blank && bi < LINE_BYTES)
                begin
                    addr = send_row + bi;
                    if (addr < PLANE_BYTES)
                    begin
                        res.red   = plane_mem[CH_RED][shown_buf][addr];
                        res.green = plane_mem[CH_GREEN][shown_buf][addr];
                        res.blue  = plane_mem[CH_BLUE][shown_buf][addr];
                    end
                end
            end
            OP_END_LINE:
            begin
                // latch the row, then advance the vertical timing
                if (line_cnt == 0)
                    row_ofs = '0;
                if (line_cnt < VISIBLE_LINES)
                begin
                    send_blank = 1'b0;
                    send_row   = row_ofs;
                end
                else
                    send_blank = 1'b1;
                if (line_cnt[0])
                    row_ofs = row_ofs + ROW_W'(LINE_BYTES);
                line_cnt = line_cnt + 1'b1;
                if (line_cnt == cfg_vsync_start)
                    vsync_lvl = 1'b1;
                else if (line_cnt == cfg_vsync_end)
                    vsync_lvl = 1'b0;
                else if (line_cnt == cfg_total_lines)
                    line_cnt = '0;
            end
            default:
                ;
        endcase
        res.vsync  = vsync_lvl;
        res.line   = line_cnt;
        res.vblank = (line_cnt >= VISIBLE_LINES);
        return res;
    endfunction

    // random field values, mostly in range
    function automatic logic [X_W-1:0] rand_x();
        if ($urandom_range(0, 9) == 0)
            return X_W'($urandom_range(0, 1023));
        return X_W'($urandom_range(0, VISIBLE_WIDTH - 1));
    endfunction

    function automatic logic [Y_W-1:0] rand_y();
        if ($urandom_range(0, 9) == 0)
            return Y_W'($urandom_range(0, 511));
        return Y_W'($urandom_range(0, VISIBLE_HEIGHT - 1));
    endfunction

    function automatic logic [COLOR_W-1:0] rand_color();
        return COLOR_W'($urandom());
    endfunction

    function automatic logic [BI_W-1:0] rand_bi();
        if ($urandom_range(0, 7) == 0)
            return BI_W'($urandom_range(0, 127));
        return BI_W'($urandom_range(0, LINE_BYTES - 1));
    endfunction

    // offer one item and record its expected result on acceptance
    task automatic send_item(logic [OP_W-1:0] op, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                             logic [COLOR_W-1:0] color, logic [BI_W-1:0] bi);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_TDATA_W'({bi, color, y, x});
        do @(posedge clk); while (!s_tready);
        pending_scan_results.push_back(predict_scan_result(op, x, y, color, bi));
    endtask

    task automatic send_random_item();
        int              pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 36)
            op = OP_SET_PIXEL;
        else if (pick < 64)
            op = OP_FETCH;
        else if (pick < 88)
            op = OP_END_LINE;
        else if (pick < 93)
            op = OP_FLIP;
        else if (pick < 98)
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else if (fills_left > 0)
        begin
            op = OP_FILL;
            fills_left--;
        end
        else
            op = OP_END_LINE;
        send_item(op, rand_x(), rand_y(), rand_color(), rand_bi());
    endtask

    // stop offering and let every pending result come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_scan_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_timing_reg(int idx, logic [LINE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_VSYNC_START: cfg_vsync_start = value;
            REG_VSYNC_END:   cfg_vsync_end   = value;
            REG_TOTAL_LINES: cfg_total_lines = value;
            default:         ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(value))
            report_mismatch("register read back", APB_DATA_W'(value), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing(logic [LINE_W-1:0] vs_start, logic [LINE_W-1:0] vs_end,
                                  logic [LINE_W-1:0] total);
        write_timing_reg(REG_VSYNC_START, vs_start);
        write_timing_reg(REG_VSYNC_END, vs_end);
        write_timing_reg(REG_TOTAL_LINES, total);
    endtask

    // bring the line counter back to zero with one end of line
    task automatic home_line_counter();
        logic [LINE_W-1:0] next_line;
        wait_for_results();
        next_line = line_cnt + 1'b1;
        program_timing(next_line + 2'd2, next_line + 2'd2, next_line);
        send_item(OP_END_LINE, rand_x(), rand_y(), rand_color(), rand_bi());
        wait_for_results();
    endtask

    // result side: random stalls, long hold on request, field checks
    task automatic check_scan_result(logic [OUT_TDATA_W-1:0] data);
        scan_result_t want;
        if (pending_scan_results.size() == 0)
        begin
            report_mismatch("result with no item pending", '0, data[31:0]);
            return;
        end
        want = pending_scan_results.pop_front();
        if (data[7:0] !== want.red)
            report_mismatch("red_byte", want.red, data[7:0]);
        if (data[15:8] !== want.green)
            report_mismatch("green_byte", want.green, data[15:8]);
        if (data[23:16] !== want.blue)
            report_mismatch("blue_byte", want.blue, data[23:16]);
        if (data[24] !== want.vsync)
            report_mismatch("vsync_active", want.vsync, data[24]);
        if (data[34:25] !== want.line)
            report_mismatch("current_line", want.line, data[34:25]);
        if (data[35] !== want.vblank)
            report_mismatch("in_vblank", want.vblank, data[35]);
    endtask

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 19) : 0;
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_scan_result(m_tdata);
        end
    end

    // field extremes, every opcode, blank fetch, out of range cases, both fills
    task automatic test_directed();
        send_item(OP_FETCH, '0, '0, '0, '0);
        send_item(OP_SET_PIXEL, '0, '0, 16'hffff, '0);
        send_item(OP_SET_PIXEL, 10'd1, '0, 16'h0821, 7'd127);
        send_item(OP_SET_PIXEL, X_W'(VISIBLE_WIDTH - 1), Y_W'(VISIBLE_HEIGHT - 1),
                  16'hffff, '0);
        send_item(OP_SET_PIXEL, X_W'(VISIBLE_WIDTH), '0, 16'hffff, '0);
        send_item(OP_SET_PIXEL, '0, Y_W'(VISIBLE_HEIGHT), 16'hffff, '0);
        send_item(OP_SET_PIXEL, 10'h3ff, 9'h1ff, 16'hffff, 7'h7f);
        // all bits but the channel bits: clears the pixel
        send_item(OP_SET_PIXEL, 10'd1, '0, 16'hf7de, '0);
        send_item(OP_FLIP, '0, '0, '0, '0);
        send_item(OP_END_LINE, '0, '0, '0, '0);
        send_item(OP_FETCH, '0, '0, '0, 7'd0);
        send_item(OP_FETCH, '0, '0, '0, 7'd1);
        send_item(OP_FETCH, '0, '0, '0, BI_W'(LINE_BYTES - 1));
        send_item(OP_FETCH, '0, '0, '0, BI_W'(LINE_BYTES));
        send_item(OP_FETCH, 10'h3ff, 9'h1ff, 16'hffff, 7'h7f);
        send_item(OP_UNUSED_LO, 10'h3ff, 9'h1ff, 16'hffff, 7'h7f);
        send_item(OP_UNUSED_LO + 1'b1, 10'h155, 9'h0aa, 16'h5555, 7'h2a);
        send_item(OP_UNUSED_HI, 10'h2aa, 9'h155, 16'haaaa, 7'h55);
        send_item(OP_FILL, '0, '0, 16'hffff, '0);
        send_item(OP_FLIP, '0, '0, '0, '0);
        send_item(OP_FETCH, '0, '0, '0, 7'd1);
        send_item(OP_FETCH, '0, '0, '0, BI_W'(VISIBLE_BYTES));
        send_item(OP_FETCH, '0, '0, '0, BI_W'(VISIBLE_BYTES + 1));
        send_item(OP_FILL, '0, '0, 16'h0000, '0);
        send_item(OP_FETCH, '0, '0, '0, 7'd1);
        wait_for_results();
    endtask

    // draw a frame, show it, then scan lines through vsync and the line wrap
    task automatic test_frame_scan();
        program_timing(10'd20, 10'd30, 10'd60);
        // red and blue filled, green cleared
        send_item(OP_FILL, rand_x(), rand_y(), 16'h0801 | (rand_color() & ~16'h0821),
                  rand_bi());
        repeat (30)
            send_item(OP_SET_PIXEL, rand_x(), rand_y(), rand_color(), rand_bi());
        send_item(OP_FLIP, rand_x(), rand_y(), rand_color(), rand_bi());
        for (int n = 0; n < 80; n++)
        begin
            // a stretch with no idling on either side
            idle_on = !(n >= 30 && n < 50);
            send_item(OP_END_LINE, rand_x(), rand_y(), rand_color(), rand_bi());
            if (!send_blank || $urandom_range(0, 15) == 0)
                send_item(OP_FETCH, rand_x(), rand_y(), rand_color(), rand_bi());
        end
        idle_on = 1'b1;
        wait_for_results();
    endtask

    // register extremes and equal registers pre-empting each other
    task automatic test_timing_extremes();
        home_line_counter();
        program_timing(10'd0, 10'd0, 10'd1);
        repeat (4)
        begin
            send_item(OP_END_LINE, rand_x(), rand_y(), rand_color(), rand_bi());
            send_item(OP_FETCH, rand_x(), rand_y(), rand_color(), rand_bi());
        end
        wait_for_results();
        program_timing(10'd1, 10'd2, 10'd3);
        repeat (8)
            send_item(OP_END_LINE, rand_x(), rand_y(), rand_color(), rand_bi());
        home_line_counter();
        program_timing(10'd1023, 10'd1023, 10'd1023);
        repeat (4)
            send_item(OP_END_LINE, rand_x(), rand_y(), rand_color(), rand_bi());
        home_line_counter();
        program_timing(10'd2, 10'd2, 10'd2);
        repeat (4)
            send_item(OP_END_LINE, rand_x(), rand_y(), rand_color(), rand_bi());
        home_line_counter();
        program_timing(VSYNC_START_RST, VSYNC_END_RST, TOTAL_LINES_RST);
        repeat (3)
            send_item(OP_END_LINE, rand_x(), rand_y(), rand_color(), rand_bi());
        wait_for_results();
    endtask

    // random mixes under short, full-range and default timings
    task automatic test_random_mix();
        logic [LINE_W-1:0] total;
        home_line_counter();
        total = LINE_W'($urandom_range(2, 60));
        program_timing(LINE_W'($urandom_range(0, total)), LINE_W'($urandom_range(0, total)),
                       total);
        repeat (60)
            send_random_item();
        wait_for_results();
        program_timing(LINE_W'($urandom_range(0, 1023)), LINE_W'($urandom_range(0, 1023)),
                       LINE_W'($urandom_range(1, 1023)));
        repeat (60)
            send_random_item();
        home_line_counter();
        program_timing(VSYNC_START_RST, VSYNC_END_RST, TOTAL_LINES_RST);
        repeat (60)
            send_random_item();
        wait_for_results();
    endtask

    // long output hold while items keep coming, so the input stalls
    task automatic test_output_stall();
        fills_left = 0;
        idle_on    = 1'b0;
        hold_req   = 400;
        repeat (24)
            send_random_item();
        idle_on = 1'b1;
        wait_for_results();
    endtask

    // main sequence
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_frame_scan();
        test_timing_extremes();
        test_random_mix();
        test_output_stall();
        wait_for_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bfsc_pkg.sv
rtl/core/bfsc_ram.sv
rtl/core/bfsc_cfg.sv
rtl/core/bfsc_ctrl.sv
rtl/core/bfsc_datapath.sv
rtl/core/bitplane_framebuffer_scanout_core.sv
verif/tb_bitplane_framebuffer_scanout_core.sv
